// ===== hw/rtl/synth_divider_register_planner_defines.svh =====
// Assertion macros shared by the synthesizer register planner.
`ifndef SYNTH_DIVIDER_REGISTER_PLANNER_DEFINES_SVH
`define SYNTH_DIVIDER_REGISTER_PLANNER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SDRP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("planner check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define SDRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("planner check failed");

`endif

// ===== hw/rtl/sdrp_pkg.sv =====
package sdrp_pkg;

  localparam int FreqW    = 28;
  localparam int ChanW    = 2;
  localparam int XtalW    = 25;
  localparam int MsW      = 11;
  localparam int RbitW    = 3;
  localparam int P1W      = 18;
  localparam int P2W      = 20;
  localparam int DivNumW  = 45;
  localparam int DivDenW  = 28;
  localparam int DivCntW  = 6;
  localparam int PosW     = 5;

  localparam logic [XtalW-1:0]   XtalReset  = 25'd25000000;
  localparam logic [FreqW-1:0]   MinTarget  = 28'd500000;
  localparam logic [FreqW-1:0]   IntTarget  = 28'd100000000;
  localparam logic [DivNumW-1:0] VcoMax     = 45'd750000000;
  localparam logic [DivDenW-1:0] FeedC      = 28'd1048575;
  localparam logic [MsW-1:0]     MsInt      = 11'd4;
  localparam logic [MsW-1:0]     MsMin      = 11'd6;
  localparam logic [MsW-1:0]     MsMax      = 11'd1800;
  localparam logic [P1W-1:0]     P1Offset   = 18'd512;

  // Positions in the full write list of one request.
  localparam logic [PosW-1:0] PosFbBase = 5'd7;
  localparam logic [PosW-1:0] PosMode   = 5'd15;
  localparam logic [PosW-1:0] PosMsBase = 5'd16;
  localparam logic [PosW-1:0] PosMsLast = 5'd23;
  localparam logic [PosW-1:0] PosPll    = 5'd24;

  localparam logic [7:0] AddrFbBase = 8'd26;
  localparam logic [7:0] AddrMode   = 8'd16;
  localparam logic [7:0] AddrMsBase = 8'd42;
  localparam logic [7:0] AddrPllRst = 8'd177;
  localparam logic [7:0] DataPllRst = 8'h20;
  localparam logic [7:0] ModeFrac   = 8'h0F;
  localparam logic [7:0] ModeInt    = 8'h4F;
  localparam logic [7:0] MsIntBits  = 8'h0C;

  typedef struct packed {
    logic [FreqW-1:0] freq;
    logic [ChanW-1:0] channel;
  } in_word_t;

  typedef struct packed {
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic       last;
  } out_word_t;

  // Everything the write list needs, handed from the sequencer to the emitter.
  typedef struct packed {
    logic             do_init;
    logic             pll_rst;
    logic             is_int;
    logic [RbitW-1:0] rbit;
    logic [MsW-1:0]   ms;
    logic [P1W-1:0]   p1;
    logic [P2W-1:0]   p2;
  } plan_t;

  // Fixed init writes as {address, data}.
  localparam logic [15:0] InitSeq [7] = '{
    16'h03FF, 16'h1180, 16'h1280, 16'h100F, 16'hB7C0, 16'hB1AC, 16'h03FE
  };

  // Address and data of the write at a given position of the list.
  function automatic logic [15:0] write_at(input logic [PosW-1:0] pos, input plan_t p);
    logic [P1W-1:0] q1;
    logic [2:0]     off;
    logic [7:0]     d;
    logic [15:0]    w;
    q1  = {p.ms, 7'd0} - P1Offset;
    off = 3'(pos - PosMsBase);
    d   = 8'd0;
    w   = 16'd0;
    if (pos < PosFbBase) begin
      w = InitSeq[3'(pos)];
    end else if (pos < PosMode) begin
      off = 3'(pos - PosFbBase);
      case (off)
        3'd0:    d = FeedC[15:8];
        3'd1:    d = FeedC[7:0];
        3'd2:    d = {6'd0, p.p1[17:16]};
        3'd3:    d = p.p1[15:8];
        3'd4:    d = p.p1[7:0];
        3'd5:    d = {FeedC[19:16], p.p2[19:16]};
        3'd6:    d = p.p2[15:8];
        default: d = p.p2[7:0];
      endcase
      w = {AddrFbBase + 8'(off), d};
    end else if (pos == PosMode) begin
      w = {AddrMode, p.is_int ? ModeInt : ModeFrac};
    end else if (pos <= PosMsLast) begin
      case (off)
        3'd1:    d = 8'd1;
        3'd2:    d = p.is_int ? (MsIntBits | {1'b0, p.rbit, 4'd0})
                              : {1'b0, p.rbit, 2'd0, q1[17:16]};
        3'd3:    d = p.is_int ? 8'd0 : q1[15:8];
        3'd4:    d = p.is_int ? 8'd0 : q1[7:0];
        default: d = 8'd0;
      endcase
      w = {AddrMsBase + 8'(off), d};
    end else begin
      w = {AddrPllRst, DataPllRst};
    end
    return w;
  endfunction

endpackage

// ===== hw/rtl/synth_divider_register_planner.sv =====
// An accepted request runs four passes through the shared bit-serial divider
// before its first write word (three passes at 100 MHz and above).
// Throughput: one request at a time; the next is taken once the last word
// (up to 25 words, one per cycle without stall) has been delivered.
// Ignored requests do not stall the input. Reset restores the 25 MHz crystal and init.
`include "synth_divider_register_planner_defines.svh"

module synth_divider_register_planner (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sdrp_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sdrp_pkg::out_word_t                 out_data,
  input  logic                                cfg_we,
  input  logic [sdrp_pkg::XtalW-1:0]          cfg_data
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMsGo  = 3'd1;
  localparam logic [2:0] StMsWt  = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StAGo   = 3'd4;
  localparam logic [2:0] StDivWt = 3'd5;
  localparam logic [2:0] StEmit  = 3'd6;

  // Which of the three divisions (two by the crystal, one by the feedback denominator) is running.
  localparam logic [1:0] PhA = 2'd0;
  localparam logic [1:0] PhB = 2'd1;
  localparam logic [1:0] PhP = 2'd2;

  logic [2:0]                    state_r, state_nxt;
  logic [1:0]                    ph_r, ph_nxt;
  logic [sdrp_pkg::XtalW-1:0]    xtal_r, xtal_nxt;
  logic                          init_done_r, init_done_nxt;
  logic [sdrp_pkg::MsW-1:0]      last_div_r, last_div_nxt;
  logic [sdrp_pkg::FreqW-1:0]    target_r, target_nxt;
  logic [sdrp_pkg::RbitW-1:0]    rbit_r, rbit_nxt;
  logic [sdrp_pkg::MsW-1:0]      ms_r, ms_nxt;
  logic [37:0]                   vco_r, vco_nxt;
  logic [10:0]                   alo_r, alo_nxt;
  logic [sdrp_pkg::XtalW-1:0]    rem_r, rem_nxt;
  logic [sdrp_pkg::P2W-1:0]      b_r, b_nxt;
  logic                          do_init_r, do_init_nxt;

  logic                          accept, req_ok;
  logic [sdrp_pkg::RbitW-1:0]    rbit_c;
  logic [sdrp_pkg::FreqW-1:0]    target_c;
  logic [sdrp_pkg::XtalW-1:0]    xt;
  logic [30:0]                   q_even;
  logic                          div_start, div_done;
  logic [sdrp_pkg::DivNumW-1:0]  div_num, div_quot;
  logic [sdrp_pkg::DivDenW-1:0]  div_den, div_rem;
  logic                          emit_start, emit_busy;
  sdrp_pkg::plan_t               plan;
  logic [sdrp_pkg::MsW-1:0]      base_div;

  assign accept = in_valid && !in_stall;
  assign req_ok = in_data.channel == '0 && in_data.freq != '0;
  assign xt     = (xtal_r == '0) ? sdrp_pkg::XtalW'(1) : xtal_r;

  // Output divider search: smallest shift that reaches the minimum target (7 if none does).
  always_comb begin
    rbit_c = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if ({7'd0, in_data.freq} << i >= {7'd0, sdrp_pkg::MinTarget}) begin
        rbit_c = 3'(i);
      end
    end
    target_c = in_data.freq << rbit_c;
  end

  // Operand selection for the shared divider.
  always_comb begin
    div_num = '0;
    div_den = sdrp_pkg::DivDenW'(xt);
    case (ph_r)
      PhA:     div_num = sdrp_pkg::DivNumW'(vco_r);
      PhB:     div_num = {rem_r, 20'd0} - sdrp_pkg::DivNumW'(rem_r)
                         + sdrp_pkg::DivNumW'(xt >> 1);
      default: begin
        div_num = sdrp_pkg::DivNumW'({b_r, 7'd0});
        div_den = sdrp_pkg::FeedC;
      end
    endcase
    if (state_r == StMsGo) begin
      div_num = sdrp_pkg::VcoMax;
      div_den = target_r;
    end
  end

  assign div_start = state_r == StMsGo || state_r == StAGo;
  assign q_even    = div_quot[30:0] + {30'd0, div_quot[0]};
  assign base_div  = do_init_r ? '0 : last_div_r;

  // Plan handed to the emitter once the last division ends.
  // The feedback quotient reaches 128 when b rounds up to the full denominator.
  always_comb begin
    plan.do_init = do_init_r;
    plan.is_int  = ms_r == sdrp_pkg::MsInt;
    plan.pll_rst = ms_r != base_div || plan.is_int;
    plan.rbit    = rbit_r;
    plan.ms      = ms_r;
    plan.p1      = {alo_r, 7'd0} + {10'd0, div_quot[7:0]} - sdrp_pkg::P1Offset;
    plan.p2      = div_rem[sdrp_pkg::P2W-1:0];
  end

  // Request sequencer.
  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    xtal_nxt      = cfg_we ? cfg_data : xtal_r;
    init_done_nxt = init_done_r;
    last_div_nxt  = last_div_r;
    target_nxt    = target_r;
    rbit_nxt      = rbit_r;
    ms_nxt        = ms_r;
    vco_nxt       = vco_r;
    alo_nxt       = alo_r;
    rem_nxt       = rem_r;
    b_nxt         = b_r;
    do_init_nxt   = do_init_r;
    emit_start    = 1'b0;
    case (state_r)
      StIdle: begin
        if (accept && req_ok) begin
          target_nxt  = target_c;
          rbit_nxt    = rbit_c;
          do_init_nxt = !init_done_r;
          ph_nxt      = PhA;
          if (target_c >= sdrp_pkg::IntTarget) begin
            ms_nxt    = sdrp_pkg::MsInt;
            state_nxt = StMul;
          end else begin
            state_nxt = StMsGo;
          end
        end
      end
      StMsGo: state_nxt = StMsWt;
      StMsWt: begin
        if (div_done) begin
          if (q_even < 31'(sdrp_pkg::MsMin)) begin
            ms_nxt = sdrp_pkg::MsMin;
          end else if (q_even > 31'(sdrp_pkg::MsMax)) begin
            ms_nxt = sdrp_pkg::MsMax;
          end else begin
            ms_nxt = q_even[sdrp_pkg::MsW-1:0];
          end
          state_nxt = StMul;
        end
      end
      StMul: begin
        vco_nxt   = target_r * ms_r;
        state_nxt = StAGo;
      end
      StAGo: state_nxt = StDivWt;
      StDivWt: begin
        if (div_done) begin
          case (ph_r)
            PhA: begin
              alo_nxt   = div_quot[10:0];
              rem_nxt   = div_rem[sdrp_pkg::XtalW-1:0];
              ph_nxt    = PhB;
              state_nxt = StAGo;
            end
            PhB: begin
              b_nxt     = div_quot[sdrp_pkg::P2W-1:0];
              ph_nxt    = PhP;
              state_nxt = StAGo;
            end
            default: begin
              emit_start    = 1'b1;
              init_done_nxt = 1'b1;
              if (plan.pll_rst) begin
                last_div_nxt = ms_r;
              end else begin
                last_div_nxt = base_div;
              end
              state_nxt = StEmit;
            end
          endcase
        end
      end
      StEmit: begin
        if (!emit_busy && !emit_start) begin
          state_nxt = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      ph_r        <= PhA;
      xtal_r      <= sdrp_pkg::XtalReset;
      init_done_r <= 1'b0;
      last_div_r  <= '0;
      do_init_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      xtal_r      <= xtal_nxt;
      init_done_r <= init_done_nxt;
      last_div_r  <= last_div_nxt;
      do_init_r   <= do_init_nxt;
    end
    target_r <= target_nxt;
    rbit_r   <= rbit_nxt;
    ms_r     <= ms_nxt;
    vco_r    <= vco_nxt;
    alo_r    <= alo_nxt;
    rem_r    <= rem_nxt;
    b_r      <= b_nxt;
  end

  assign in_stall = state_r != StIdle;

  sdrp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  sdrp_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (emit_start),
    .plan      (plan),
    .busy      (emit_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A taken request blocks the input until its words are out.
  `SDRP_ASSERT_NEXT(a_req_blocks, accept && req_ok, in_stall)
  // No new word is accepted while results are still pending.
  `SDRP_ASSERT_NOW(a_out_blocks_in, out_valid, in_stall)
  // After the flagged last word leaves, the output goes quiet.
  `SDRP_ASSERT_NEXT(a_last_ends, out_valid && !out_stall && out_data.last, !out_valid)

endmodule

// ===== hw/rtl/sdrp_div.sv =====
// Restoring divider, one quotient bit per cycle.
module sdrp_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [sdrp_pkg::DivNumW-1:0]     num,
  input  logic [sdrp_pkg::DivDenW-1:0]     den,
  output logic                             done,
  output logic [sdrp_pkg::DivNumW-1:0]     quot,
  output logic [sdrp_pkg::DivDenW-1:0]     rem
);

  logic [sdrp_pkg::DivCntW-1:0] cnt_r, cnt_nxt;
  logic                         done_r, done_nxt;
  logic [sdrp_pkg::DivNumW-1:0] q_r, q_nxt;
  logic [sdrp_pkg::DivDenW-1:0] rem_r, rem_nxt;
  logic [sdrp_pkg::DivDenW-1:0] den_r, den_nxt;
  logic [sdrp_pkg::DivDenW:0]   trial;
  logic                         ge;

  // One shift-compare-subtract step.
  always_comb begin
    trial    = {rem_r, q_r[sdrp_pkg::DivNumW-1]};
    ge       = trial >= {1'b0, den_r};
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      cnt_nxt = sdrp_pkg::DivCntW'(sdrp_pkg::DivNumW);
      q_nxt   = num;
      rem_nxt = '0;
      den_nxt = den;
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? sdrp_pkg::DivDenW'(trial - {1'b0, den_r})
                    : sdrp_pkg::DivDenW'(trial);
      q_nxt    = {q_r[sdrp_pkg::DivNumW-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = cnt_r == sdrp_pkg::DivCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

// ===== hw/rtl/sdrp_emit.sv =====
// Walks the write list of one request into a registered output word.
module sdrp_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  sdrp_pkg::plan_t     plan,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output sdrp_pkg::out_word_t out_data
);

  logic                      active_r, active_nxt;
  logic [sdrp_pkg::PosW-1:0] pos_r, pos_nxt;
  logic [sdrp_pkg::PosW-1:0] end_pos;
  sdrp_pkg::plan_t           plan_r, plan_nxt;
  logic                      ov_r, ov_nxt;
  sdrp_pkg::out_word_t       word_r, word_nxt;
  logic [15:0]               w;
  logic                      load;

  // Next word and output register update.
  always_comb begin
    end_pos    = plan_r.pll_rst ? sdrp_pkg::PosPll : sdrp_pkg::PosMsLast;
    w          = sdrp_pkg::write_at(pos_r, plan_r);
    load       = active_r && (!ov_r || !out_stall);
    active_nxt = active_r;
    pos_nxt    = pos_r;
    plan_nxt   = plan_r;
    ov_nxt     = ov_r && out_stall;
    word_nxt   = word_r;
    if (start) begin
      active_nxt = 1'b1;
      plan_nxt   = plan;
      pos_nxt    = plan.do_init ? '0 : sdrp_pkg::PosFbBase;
    end else if (load) begin
      ov_nxt            = 1'b1;
      word_nxt.reg_addr = w[15:8];
      word_nxt.reg_data = w[7:0];
      word_nxt.last     = pos_r == end_pos;
      pos_nxt           = pos_r + 1'b1;
      active_nxt        = pos_r != end_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ov_r     <= ov_nxt;
    end
    pos_r  <= pos_nxt;
    plan_r <= plan_nxt;
    word_r <= word_nxt;
  end

  assign busy      = active_r || ov_r;
  assign out_valid = ov_r;
  assign out_data  = word_r;

endmodule
